// ----- rtl/core/ccnt_pkg.sv -----
// Shared types and constants of the cycle counter timebase.
`timescale 1ns / 1ps

package ccnt_pkg;

	localparam int unsigned COUNT_W    = 64;
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned MHZ_W      = 10;
	localparam int unsigned SUBSEC_W   = 20;
	localparam int unsigned PART_W     = 10;
	localparam int unsigned SEC_W      = 44;
	localparam int unsigned Q32_W      = 45;
	localparam int unsigned DIV_STEPS  = COUNT_W;
	localparam int unsigned SPLIT_STEPS = PART_W;

	localparam logic [SUBSEC_W:0]   US_PER_SEC     = (SUBSEC_W + 1)'(1000000);
	localparam logic [SUBSEC_W-1:0] US_PER_MS      = SUBSEC_W'(1000);
	localparam logic [SUBSEC_W-1:0] SPLIT_DIV_INIT = US_PER_MS << (SPLIT_STEPS - 1);

	localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(168);

	localparam logic OP_TIMESTAMP = 1'b0;
	localparam logic OP_DELTA     = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_SPLIT = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

endpackage

// ----- rtl/core/cycle_counter_timebase_unit.sv -----
// Top level of the cycle counter timebase: wrap extension, control and result register.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     op, counter_now, prev_count
//   out      out_valid / out_stall   seconds, millis, micros, total_micros,
//                                    elapsed_cycles, elapsed_seconds_q32
//   cfg      cfg_wr_en               cfg_wr_data (clock in MHz)
//
// An item passes from transfer to result through the bit-serial chained divider, then the
// millisecond split, then the load of the result register. The next transfer can follow
// once the result is loaded, so the unit works on one item at a time.
// in_stall is high from the transfer until the result is loaded into the output register.
// A result waiting under out_stall holds back the next result, not the next transfer.
// Reset clears the wrap state and sets the clock register to 168 MHz.
`timescale 1ns / 1ps

module cycle_counter_timebase_unit
	import ccnt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [MHZ_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [SAMPLE_W-1:0] counter_now,
	input  logic [SAMPLE_W-1:0] prev_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SEC_W-1:0]    seconds,
	output logic [PART_W-1:0]   millis,
	output logic [PART_W-1:0]   micros,
	output logic [COUNT_W-1:0]  total_micros,
	output logic [SAMPLE_W-1:0] elapsed_cycles,
	output logic [Q32_W-1:0]    elapsed_seconds_q32
);

	state_t              state_q;
	logic [MHZ_W-1:0]    mhz_q;
	logic [SAMPLE_W-1:0] last_sample_q;
	logic [SAMPLE_W-1:0] wrap_count_q;
	logic                op_q;
	logic [SAMPLE_W-1:0] delta_q;
	logic                out_valid_q;

	logic                accept;
	logic [SAMPLE_W-1:0] wrap_next;
	logic [SAMPLE_W-1:0] delta;
	logic [COUNT_W-1:0]  dividend;
	logic [MHZ_W-1:0]    mhz_eff;
	logic                div_done;
	logic [COUNT_W-1:0]  quot_us;
	logic [COUNT_W-1:0]  quot_sec;
	logic [SUBSEC_W-1:0] rem_us;
	logic                split_done;
	logic [PART_W-1:0]   split_ms;
	logic [PART_W-1:0]   split_us;
	logic                load_out;
	logic [SEC_W-1:0]    sec_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign wrap_next = (counter_now < last_sample_q) ? (wrap_count_q + 1'b1) : wrap_count_q;
	assign delta     = counter_now - prev_count;
	assign dividend  = (op == OP_DELTA) ? {delta, SAMPLE_W'(0)} : {wrap_next, counter_now};
	assign mhz_eff   = (mhz_q == '0) ? MHZ_W'(1) : mhz_q;
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign sec_sat   = (quot_sec[COUNT_W-1:SEC_W] != '0) ? '1 : quot_sec[SEC_W-1:0];

	ccnt_chain_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (dividend),
		.mhz      (mhz_eff),
		.done     (div_done),
		.quot_us  (quot_us),
		.quot_sec (quot_sec),
		.rem_us   (rem_us)
	);

	ccnt_ms_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.value  (rem_us),
		.done   (split_done),
		.millis (split_ms),
		.micros (split_us)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhz_q <= MHZ_RESET;
		end else if (cfg_wr_en) begin
			mhz_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_sample_q <= '0;
			wrap_count_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_sample_q <= counter_now;
						wrap_count_q  <= wrap_next;
						state_q       <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (split_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			delta_q <= delta;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (op_q == OP_DELTA) begin
				seconds             <= '0;
				millis              <= '0;
				micros              <= '0;
				total_micros        <= '0;
				elapsed_cycles      <= delta_q;
				elapsed_seconds_q32 <= quot_sec[Q32_W-1:0];
			end else begin
				seconds             <= sec_sat;
				millis              <= split_ms;
				micros              <= split_us;
				total_micros        <= quot_us;
				elapsed_cycles      <= '0;
				elapsed_seconds_q32 <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/ccnt_chain_div.sv -----
// Bit-serial chained divider: count by the clock in MHz, then by one million.
`timescale 1ns / 1ps

module ccnt_chain_div
	import ccnt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [COUNT_W-1:0]  dividend,
	input  logic [MHZ_W-1:0]    mhz,
	output logic                done,
	output logic [COUNT_W-1:0]  quot_us,
	output logic [COUNT_W-1:0]  quot_sec,
	output logic [SUBSEC_W-1:0] rem_us
);

	logic [COUNT_W-1:0]  a_q;
	logic [COUNT_W-1:0]  b_q;
	logic [MHZ_W-1:0]    ra_q;
	logic [SUBSEC_W-1:0] rb_q;
	logic [$clog2(DIV_STEPS)-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [MHZ_W:0]    ta;
	logic              qa;
	logic [MHZ_W:0]    ra_next;
	logic [SUBSEC_W:0] tb;
	logic              qb;
	logic [SUBSEC_W:0] rb_next;

	always_comb begin
		ta      = {ra_q, a_q[COUNT_W-1]};
		qa      = (ta >= {1'b0, mhz});
		ra_next = qa ? (ta - {1'b0, mhz}) : ta;
		tb      = {rb_q, qa};
		qb      = (tb >= US_PER_SEC);
		rb_next = qb ? (tb - US_PER_SEC) : tb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= dividend;
			b_q  <= '0;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			a_q  <= {a_q[COUNT_W-2:0], qa};
			b_q  <= {b_q[COUNT_W-2:0], qb};
			ra_q <= ra_next[MHZ_W-1:0];
			rb_q <= rb_next[SUBSEC_W-1:0];
		end
	end

	assign done     = done_q;
	assign quot_us  = a_q;
	assign quot_sec = b_q;
	assign rem_us   = rb_q;

endmodule

// ----- rtl/core/ccnt_ms_split.sv -----
// Bit-serial split of the microseconds within a second into milliseconds and microseconds.
`timescale 1ns / 1ps

module ccnt_ms_split
	import ccnt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUBSEC_W-1:0] value,
	output logic                done,
	output logic [PART_W-1:0]   millis,
	output logic [PART_W-1:0]   micros
);

	logic [SUBSEC_W-1:0] r_q;
	logic [SUBSEC_W-1:0] dv_q;
	logic [PART_W-1:0]   ms_q;
	logic [$clog2(SPLIT_STEPS)-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic                ge;

	assign ge = (r_q >= dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(SPLIT_STEPS))'(SPLIT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= value;
			dv_q <= SPLIT_DIV_INIT;
			ms_q <= '0;
		end else if (busy_q) begin
			r_q  <= ge ? (r_q - dv_q) : r_q;
			dv_q <= dv_q >> 1;
			ms_q <= {ms_q[PART_W-2:0], ge};
		end
	end

	assign done   = done_q;
	assign millis = ms_q;
	assign micros = r_q[PART_W-1:0];

endmodule
